// ===== src/cct_pkg.sv =====
// Shared types, reset values and calendar helper functions for the tick clock.
// Used by cct_next and calendar_clock_tick; depends on nothing else.
`timescale 1ns / 1ps

package cct_pkg;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [2:0]  step;
  } cal_t;

  localparam logic [13:0] ResetYear  = 14'd2000;
  localparam logic [3:0]  ResetMonth = 4'd1;
  localparam logic [4:0]  ResetDay   = 5'd1;
  localparam logic [4:0]  ResetHour  = 5'd0;
  localparam logic [2:0]  ResetStep  = 3'd0;

  localparam logic [2:0]  StepsPerHour = 3'd6;
  localparam logic [2:0]  MaxStep      = 3'd5;
  localparam logic [2:0]  HalfStep     = 3'd3;
  localparam logic [5:0]  HoursPerDay  = 6'd24;
  localparam logic [3:0]  FirstBadMonth = 4'd13;
  localparam logic [13:0] LastYear     = 14'd9999;

  localparam logic [3:0]  MonFeb = 4'd2;
  localparam logic [3:0]  MonApr = 4'd4;
  localparam logic [3:0]  MonJun = 4'd6;
  localparam logic [3:0]  MonSep = 4'd9;
  localparam logic [3:0]  MonNov = 4'd11;

  // Multiplicative inverse of 25 modulo 2^12, and the divisibility bound.
  localparam logic [11:0] Inv25     = 12'd3113;
  localparam logic [11:0] Div25Max  = 12'd163;

  // Gregorian leap test. For a multiple of four y = 4k, y is a multiple of
  // 100 exactly when k is a multiple of 25, and of 400 when also y % 16 == 0.
  // k % 25 == 0 is checked with the modular-inverse trick: k * inv(25)
  // mod 2^12 lands in [0, 4095/25] only for multiples of 25.
  function automatic logic is_leap(input logic [13:0] y);
    logic [23:0] prod;
    logic        div25;
    prod  = 24'(y[13:2]) * 24'(Inv25);
    div25 = (prod[11:0] <= Div25Max);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MonFeb:                         len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default:                        len = 5'd31;
    endcase
    return len;
  endfunction

  // Minutes are step * 10, built as 8 * step + 2 * step.
  function automatic logic [5:0] step_minutes(input logic [2:0] s);
    return {s, 3'b000} + {2'b00, s, 1'b0};
  endfunction

endpackage

// ===== src/cct_next.sv =====
// Next-state logic of the tick clock: load, ten-minute advance and the carry
// chain into hour, day, month and year. Depends on cct_pkg.
`timescale 1ns / 1ps

module cct_next
  import cct_pkg::*;
(
  input  cal_t        cur_i,
  input  logic        kind_i,
  input  logic        paused_i,
  input  logic [13:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  logic [4:0]  load_hour_i,
  input  logic [2:0]  load_step_i,
  output cal_t        nxt_o,
  output logic        advanced_o,
  output logic        half_hour_mark_o
);

  logic [2:0] step_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] mlen;
  logic       wrap_min, wrap_hour, wrap_day;
  cal_t       tck;
  logic [3:0] month_c;

  always_comb begin
    step_inc  = cur_i.step + 3'd1;
    hour_inc  = {1'b0, cur_i.hour} + 6'd1;
    day_inc   = {1'b0, cur_i.day} + 6'd1;
    mlen      = month_len(cur_i.month, is_leap(cur_i.year));
    wrap_min  = (step_inc >= StepsPerHour);
    wrap_hour = wrap_min && (hour_inc >= HoursPerDay);
    wrap_day  = wrap_hour && (day_inc > {1'b0, mlen});

    month_c   = wrap_day ? cur_i.month + 4'd1 : cur_i.month;

    tck.step  = wrap_min ? 3'd0 : step_inc;
    tck.hour  = wrap_min ? (wrap_hour ? 5'd0 : hour_inc[4:0]) : cur_i.hour;
    tck.day   = wrap_hour ? (wrap_day ? 5'd1 : day_inc[4:0]) : cur_i.day;
    // A month outside one to twelve folds into January of the next year; years from 9999 up wrap to 0.
    if (month_c >= FirstBadMonth || month_c == 4'd0) begin
      tck.month = 4'd1;
      tck.year  = (cur_i.year >= LastYear) ? 14'd0 : cur_i.year + 14'd1;
    end else begin
      tck.month = month_c;
      tck.year  = cur_i.year;
    end
  end

  always_comb begin
    advanced_o       = 1'b0;
    half_hour_mark_o = 1'b0;
    nxt_o            = cur_i;
    if (kind_i) begin
      nxt_o.year  = load_year_i;
      nxt_o.month = load_month_i;
      nxt_o.day   = load_day_i;
      nxt_o.hour  = load_hour_i;
      nxt_o.step  = (load_step_i > MaxStep) ? MaxStep : load_step_i;
    end else if (!paused_i) begin
      nxt_o            = tck;
      advanced_o       = 1'b1;
      half_hour_mark_o = (tck.step == 3'd0) || (tck.step == HalfStep);
    end
  end

endmodule

// ===== src/calendar_clock_tick.sv =====
// Top level of the ten-minute calendar clock: state registers, result
// register and handshakes. Depends on cct_pkg and cct_next.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per transfer:
//   kind_i = 0 is a tick (ignored when paused_i is 1), kind_i = 1 loads the
//   whole date and time from the load_* fields (load_step_i above 5 is
//   clamped to 5). Every accepted item yields exactly one result on the
//   output channel (out_valid_o / out_ready_i): the date after the item,
//   minute_o = step * 10, advanced_o and half_hour_mark_o.
//   The result is registered and appears in the cycle after the item is accepted.
//   Throughput: one item per cycle while the output does not stall; the date update is a single
//   combinational pass (one 12x12 multiply for the leap test, then the
//   carry chain) between the state registers and the result register.
//   Reset: the date becomes 2000-01-01 00:00 and no result is pending.
//   Stall: while a result waits and out_ready_i is low, in_ready_o drops
//   and the result holds; a new item is taken in the same cycle that the
//   pending result is taken.

module calendar_clock_tick
  import cct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        paused_i,
  input  logic [13:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  logic [4:0]  load_hour_i,
  input  logic [2:0]  load_step_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic        advanced_o,
  output logic        half_hour_mark_o
);

  cal_t       cal_q, cal_d;
  logic       adv_d, mark_d;
  logic       out_valid_q;
  cal_t       res_q;
  logic       adv_q, mark_q;
  logic       accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  cct_next u_next (
    .cur_i            (cal_q),
    .kind_i           (kind_i),
    .paused_i         (paused_i),
    .load_year_i      (load_year_i),
    .load_month_i     (load_month_i),
    .load_day_i       (load_day_i),
    .load_hour_i      (load_hour_i),
    .load_step_i      (load_step_i),
    .nxt_o            (cal_d),
    .advanced_o       (adv_d),
    .half_hour_mark_o (mark_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.year  <= ResetYear;
      cal_q.month <= ResetMonth;
      cal_q.day   <= ResetDay;
      cal_q.hour  <= ResetHour;
      cal_q.step  <= ResetStep;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cal_q       <= cal_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled, load on accept.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= cal_d;
      adv_q  <= adv_d;
      mark_q <= mark_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign year_o           = res_q.year;
  assign month_o          = res_q.month;
  assign day_o            = res_q.day;
  assign hour_o           = res_q.hour;
  assign minute_o         = step_minutes(res_q.step);
  assign advanced_o       = adv_q;
  assign half_hour_mark_o = mark_q;

endmodule

// ===== src/cct_checker.sv =====
// Port-level checks for calendar_clock_tick and the bind that attaches them.
// Depends on calendar_clock_tick's port list only.
`timescale 1ns / 1ps

module cct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [13:0] year_o,
  input logic [5:0]  minute_o,
  input logic        advanced_o,
  input logic        half_hour_mark_o
);

  // Every accepted item leaves a result pending in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // Input side never blocks while nothing is waiting at the output.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_mark_needs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && half_hour_mark_o |-> advanced_o)
    else $error("half-hour mark without an advance");

  a_minute_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (minute_o == 6'd0 || minute_o == 6'd10 || minute_o == 6'd20 ||
                     minute_o == 6'd30 || minute_o == 6'd40 || minute_o == 6'd50))
    else $error("minute off the ten-minute grid");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(year_o) && $stable(minute_o))
    else $error("stalled result changed");

endmodule

bind calendar_clock_tick cct_checker u_cct_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .year_o           (year_o),
  .minute_o         (minute_o),
  .advanced_o       (advanced_o),
  .half_hour_mark_o (half_hour_mark_o)
);

// ===== tb/sv/cct_date_board_pkg.sv =====
// Item and result types plus the date scoreboard for the calendar clock bench.
// Depends on cct_pkg for the field widths, reset values and calendar limits.
`timescale 1ns / 1ps

package cct_date_board_pkg;
  import cct_pkg::*;

  typedef enum bit {
    KindTick = 1'b0,
    KindLoad = 1'b1
  } cmd_kind_e;

  localparam int unsigned MinutesPerStep = 10;
  localparam int unsigned MaxPrinted     = 40;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        paused;
    logic [13:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [2:0]  load_step;
  } clock_cmd_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        advanced;
    logic        half_hour_mark;
  } date_out_t;

  class date_board;
    logic [13:0] year_r;
    logic [3:0]  month_r;
    logic [4:0]  day_r;
    logic [4:0]  hour_r;
    logic [2:0]  step_r;
    date_out_t   due_q[$];
    int unsigned errors;
    int unsigned seen;

    function new();
      year_r  = ResetYear;
      month_r = ResetMonth;
      day_r   = ResetDay;
      hour_r  = ResetHour;
      step_r  = ResetStep;
      errors  = 0;
      seen    = 0;
    endfunction

    function bit leap_year(input logic [13:0] y);
      int unsigned v;
      v = 32'(y);
      return ((v % 4) == 0 && (v % 100) != 0) || (v % 400) == 0;
    endfunction

    // Months outside 1..12 count as 31 days.
    function int unsigned days_in(input logic [3:0] m, input logic [13:0] y);
      case (m)
        MonFeb: begin
          return leap_year(y) ? 29 : 28;
        end
        MonApr, MonJun, MonSep, MonNov: begin
          return 30;
        end
        default: begin
          return 31;
        end
      endcase
    endfunction

    // Step and hour rollovers use >= and the day rollover uses >, so overlong loaded values recover.
    function void advance();
      int unsigned s;
      int unsigned h;
      int unsigned d;
      s = 32'(step_r) + 1;
      if (s >= 32'(StepsPerHour)) begin
        s = 0;
        h = 32'(hour_r) + 1;
        if (h >= 32'(HoursPerDay)) begin
          h = 0;
          d = 32'(day_r) + 1;
          if (d > days_in(month_r, year_r)) begin
            d = 1;
            month_r = month_r + 4'd1;
          end
          day_r = d[4:0];
        end
        hour_r = h[4:0];
      end
      step_r = s[2:0];
      // A month of zero comes from a load or from wrapping past 15; treat it like 13.
      if (month_r >= FirstBadMonth || month_r == 4'd0) begin
        month_r = ResetMonth;
        year_r  = (year_r >= LastYear) ? 14'd0 : year_r + 14'd1;
      end
    endfunction

    function void note_item(input clock_cmd_t c);
      date_out_t r;
      r.advanced       = 1'b0;
      r.half_hour_mark = 1'b0;
      if (c.kind == KindLoad) begin
        year_r  = c.load_year;
        month_r = c.load_month;
        day_r   = c.load_day;
        hour_r  = c.load_hour;
        step_r  = (c.load_step > MaxStep) ? MaxStep : c.load_step;
      end else if (!c.paused) begin
        advance();
        r.advanced       = 1'b1;
        r.half_hour_mark = (step_r == 3'd0) || (step_r == HalfStep);
      end
      r.year   = year_r;
      r.month  = month_r;
      r.day    = day_r;
      r.hour   = hour_r;
      r.minute = 6'(step_r * MinutesPerStep);
      due_q.push_back(r);
    endfunction

    task report(input string msg);
      if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want) begin
        report($sformatf("result %0d %s got %0d want %0d", seen, name, got, want));
      end
    endtask

    task check_result(input date_out_t got);
      date_out_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result %0d arrived with no item pending (%0d-%0d-%0d %0d:%0d)",
                         seen, got.year, got.month, got.day, got.hour, got.minute));
      end else begin
        want = due_q.pop_front();
        check_field("year", got.year, want.year);
        check_field("month", got.month, want.month);
        check_field("day", got.day, want.day);
        check_field("hour", got.hour, want.hour);
        check_field("minute", got.minute, want.minute);
        check_field("advanced", got.advanced, want.advanced);
        check_field("half_hour_mark", got.half_hour_mark, want.half_hour_mark);
      end
      seen++;
    endtask
  endclass

endpackage

// ===== tb/sv/calendar_clock_tick_test.sv =====
// Top of the calendar clock bench: clock, reset, item driver, result monitor
// and watchdog. Depends on cct_pkg, cct_date_board_pkg and calendar_clock_tick.
`timescale 1ns / 1ps

module calendar_clock_tick_test;
  import cct_pkg::*;
  import cct_date_board_pkg::*;

  localparam int unsigned RandomItems = 1500;
  localparam int unsigned TailItems   = 120;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic        paused_i;
  logic [13:0] load_year_i;
  logic [3:0]  load_month_i;
  logic [4:0]  load_day_i;
  logic [4:0]  load_hour_i;
  logic [2:0]  load_step_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [13:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic        advanced_o;
  logic        half_hour_mark_o;

  date_board   board;
  bit          steady;
  int unsigned quiet_cycles = 0;

  calendar_clock_tick dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .paused_i         (paused_i),
    .load_year_i      (load_year_i),
    .load_month_i     (load_month_i),
    .load_day_i       (load_day_i),
    .load_hour_i      (load_hour_i),
    .load_step_i      (load_step_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .year_o           (year_o),
    .month_o          (month_o),
    .day_o            (day_o),
    .hour_o           (hour_o),
    .minute_o         (minute_o),
    .advanced_o       (advanced_o),
    .half_hour_mark_o (half_hour_mark_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic clock_cmd_t tick_cmd(input logic paused);
    clock_cmd_t c;
    c            = '0;
    c.kind       = KindTick;
    c.paused     = paused;
    return c;
  endfunction

  function automatic clock_cmd_t load_cmd(input logic [13:0] y, input logic [3:0] m,
                                          input logic [4:0] d, input logic [4:0] h,
                                          input logic [2:0] s, input logic paused);
    clock_cmd_t c;
    c.kind       = KindLoad;
    c.paused     = paused;
    c.load_year  = y;
    c.load_month = m;
    c.load_day   = d;
    c.load_hour  = h;
    c.load_step  = s;
    return c;
  endfunction

  // Mostly live ticks so time runs through rollovers; loads near month and
  // year ends keep the carry chain busy, and a few loads use any bit pattern.
  function automatic clock_cmd_t random_cmd();
    clock_cmd_t  c;
    int unsigned pick;
    c.kind       = KindTick;
    c.paused     = 1'($urandom);
    c.load_year  = 14'($urandom);
    c.load_month = 4'($urandom);
    c.load_day   = 5'($urandom);
    c.load_hour  = 5'($urandom);
    c.load_step  = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      c.paused = 1'b0;
    end else if (pick < 70) begin
      c.paused = 1'b1;
    end else if (pick < 86) begin
      c.kind = KindLoad;
      case ($urandom_range(0, 6))
        0: c.load_year = 14'd1900;
        1: c.load_year = 14'd2000;
        2: c.load_year = 14'd2100;
        3: c.load_year = 14'd2023;
        4: c.load_year = 14'd2024;
        5: c.load_year = LastYear;
        default: c.load_year = 14'($urandom_range(0, 9999));
      endcase
      case ($urandom_range(0, 3))
        0: c.load_month = MonFeb;
        1: c.load_month = MonApr;
        2: c.load_month = 4'd12;
        default: c.load_month = 4'($urandom_range(1, 12));
      endcase
      c.load_day  = 5'($urandom_range(27, 31));
      c.load_hour = ($urandom_range(0, 3) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
      c.load_step = 3'($urandom_range(3, 7));
    end else if (pick < 94) begin
      c.kind       = KindLoad;
      c.load_year  = 14'($urandom_range(0, 9999));
      c.load_month = 4'($urandom_range(1, 12));
      c.load_day   = 5'($urandom_range(1, 31));
      c.load_hour  = 5'($urandom_range(0, 23));
      c.load_step  = 3'($urandom_range(0, 5));
    end else begin
      c.kind = KindLoad;
    end
    return c;
  endfunction

  task automatic send_item(input clock_cmd_t c);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= c.kind;
    paused_i     <= c.paused;
    load_year_i  <= c.load_year;
    load_month_i <= c.load_month;
    load_day_i   <= c.load_day;
    load_hour_i  <= c.load_hour;
    load_step_i  <= c.load_step;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(c);
  endtask

  initial begin
    board        = new();
    steady       = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    kind_i       <= KindTick;
    paused_i     <= 1'b0;
    load_year_i  <= '0;
    load_month_i <= '0;
    load_day_i   <= '0;
    load_hour_i  <= '0;
    load_step_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(tick_cmd(1'b0));
    send_item(tick_cmd(1'b1));
    // Load goes through even with paused set; 2000 is a leap year.
    send_item(load_cmd(14'd2000, MonFeb, 5'd28, 5'd23, MaxStep, 1'b1));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'd1900, MonFeb, 5'd28, 5'd23, MaxStep, 1'b0));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'd2024, MonFeb, 5'd28, 5'd23, MaxStep, 1'b0));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'd2023, MonFeb, 5'd28, 5'd23, MaxStep, 1'b0));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(LastYear, 4'd12, 5'd31, 5'd23, MaxStep, 1'b0));
    send_item(tick_cmd(1'b0));
    // Overlong day and hour, step saturates.
    send_item(load_cmd(14'd2001, MonApr, 5'd31, 5'd31, 3'd7, 1'b0));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'd2002, 4'd15, 5'd31, 5'd23, MaxStep, 1'b0));
    send_item(tick_cmd(1'b0));
    // Month and day zero; month wraps only on a live tick.
    send_item(load_cmd(14'h3fff, 4'd0, 5'd0, 5'd0, 3'd2, 1'b0));
    send_item(tick_cmd(1'b1));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'd2005, FirstBadMonth, 5'd0, 5'd23, MaxStep, 1'b0));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'h3fff, 4'hf, 5'h1f, 5'h1f, 3'h7, 1'b1));
    send_item(tick_cmd(1'b0));
    send_item(load_cmd(14'd0, 4'd0, 5'd0, 5'd0, 3'd0, 1'b0));
    send_item(tick_cmd(1'b0));

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i >= RandomItems - TailItems) steady = 1'b1;
      send_item(random_cmd());
    end
    in_valid_i <= 1'b0;

    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("PASS calendar_clock_tick");
    end else begin
      $display("FAIL calendar_clock_tick");
    end
    $finish;
  end

  // Result side: random stall bursts, none while steady.
  initial begin
    out_ready_i <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    date_out_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {year_o, month_o, day_o, hour_o, minute_o, advanced_o, half_hour_mark_o};
      board.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL calendar_clock_tick");
      $finish;
    end
  end

endmodule
